/* src/rfb_pkg.sv */
// shared types and constants for the transmit-request frame builder
// no dependencies; imported by every rfb module and the top level
package rfb_pkg;

    localparam logic [7:0]  START_BYTE      = 8'h7E;
    localparam logic [7:0]  TYPE_TX_REQUEST = 8'h10;
    localparam logic [15:0] LEN_FIXED       = 16'h000E;
    localparam logic [15:0] MAX_PAYLOAD     = 16'd255;
    localparam logic [7:0]  SUM_BASE        = 8'hFF;

    // configuration register indexes
    localparam logic [2:0] CFG_DEST_ADDRESS     = 3'd0;
    localparam logic [2:0] CFG_FRAME_IDENT      = 3'd1;
    localparam logic [2:0] CFG_DEST_NET_ADDRESS = 3'd2;
    localparam logic [2:0] CFG_BROADCAST_RADIUS = 3'd3;
    localparam logic [2:0] CFG_TX_OPTION_BITS   = 3'd4;

    localparam logic [63:0] DEST_ADDRESS_RESET     = 64'h0013_A200_4191_DCA3;
    localparam logic [7:0]  FRAME_IDENT_RESET      = 8'h01;
    localparam logic [15:0] DEST_NET_ADDRESS_RESET = 16'hFFFE;
    localparam logic [7:0]  BROADCAST_RADIUS_RESET = 8'h00;
    localparam logic [7:0]  TX_OPTION_BITS_RESET   = 8'h00;

    // byte positions within one frame
    localparam logic [4:0] STEP_START   = 5'd0;
    localparam logic [4:0] STEP_LEN_HI  = 5'd1;
    localparam logic [4:0] STEP_LEN_LO  = 5'd2;
    localparam logic [4:0] STEP_TYPE    = 5'd3;
    localparam logic [4:0] STEP_IDENT   = 5'd4;
    localparam logic [4:0] STEP_ADDR    = 5'd5;
    localparam logic [4:0] STEP_NET_HI  = 5'd13;
    localparam logic [4:0] STEP_NET_LO  = 5'd14;
    localparam logic [4:0] STEP_RADIUS  = 5'd15;
    localparam logic [4:0] STEP_OPTIONS = 5'd16;
    localparam logic [4:0] STEP_DATA    = 5'd17;
    localparam logic [4:0] STEP_CHECK   = 5'd18;

    typedef struct packed {
        logic [63:0] dest_address;
        logic [7:0]  frame_ident;
        logic [15:0] dest_net_address;
        logic [7:0]  broadcast_radius;
        logic [7:0]  tx_option_bits;
    } cfg_t;

    typedef struct packed {
        logic [15:0] frame_len;
        logic [7:0]  data_byte;
        logic        first_of_frame;
        logic        last_of_frame;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* src/radio_api_frame_builder_top.sv */
// top level: config registers, front end, command queue and frame sequencer
// an accepted beat passes through the command queue, then the output register, on its way to m_tdata
// throughput: one output byte per cycle unless the queue is empty or m_tready stalls; a plain payload
// beat gives its data byte, a first beat gives the header bytes before it and a last beat adds the checksum
// reset: rst_n asynchronous active low; clears queue, frame state and sum, loads config defaults
// depends on rfb_pkg, rfb_front, rfb_queue, rfb_back
module radio_api_frame_builder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] data_byte, [15:8] payload_count
    input  logic        s_tuser,    // [0] first_of_frame
    input  logic        s_tlast,    // last_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] frame_byte
    output logic        m_tlast,    // end_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import rfb_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_stat;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      push;
    logic      pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEST_ADDRESS:     cfg_next.dest_address     = cfg_data;
                CFG_FRAME_IDENT:      cfg_next.frame_ident      = cfg_data[7:0];
                CFG_DEST_NET_ADDRESS: cfg_next.dest_net_address = cfg_data[15:0];
                CFG_BROADCAST_RADIUS: cfg_next.broadcast_radius = cfg_data[7:0];
                CFG_TX_OPTION_BITS:   cfg_next.tx_option_bits   = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_address     <= DEST_ADDRESS_RESET;
            cfg_reg.frame_ident      <= FRAME_IDENT_RESET;
            cfg_reg.dest_net_address <= DEST_NET_ADDRESS_RESET;
            cfg_reg.broadcast_radius <= BROADCAST_RADIUS_RESET;
            cfg_reg.tx_option_bits   <= TX_OPTION_BITS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    rfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    rfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // the front end never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("push into full command queue");

    // the sequencer only retires a command that is present
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("pop from empty command queue");

    // a stray beat outside a frame never reaches the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser && !u_front.inside_reg) |-> !push)
        else $error("stray beat pushed outside a frame");

endmodule

/* src/rfb_front.sv */
// front end: accepts payload beats, drops strays, computes the length field
// depends on rfb_pkg
module rfb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [7:0] data_byte, [15:8] payload_count
    input  logic              s_tuser,   // [0] first_of_frame
    input  logic              s_tlast,   // last_of_frame
    input  rfb_pkg::q_status_t q_stat,
    output logic              push,
    output rfb_pkg::cmd_t     push_cmd
);
    import rfb_pkg::*;

    logic        inside_reg;
    logic        inside_next;
    logic        beat;
    logic [15:0] count_wide;
    logic [15:0] count_sat;

    assign s_tready = !q_stat.full;
    assign beat     = s_tvalid && s_tready;

    always_comb
    begin
        count_wide = {8'h00, s_tdata[15:8]};
        count_sat  = (count_wide > MAX_PAYLOAD) ? MAX_PAYLOAD : count_wide;
    end

    assign push_cmd.frame_len      = LEN_FIXED + count_sat;
    assign push_cmd.data_byte      = s_tdata[7:0];
    assign push_cmd.first_of_frame = s_tuser;
    assign push_cmd.last_of_frame  = s_tlast;

    // a beat outside any frame without the first flag is dropped
    assign push = beat && (s_tuser || inside_reg);

    always_comb
    begin
        inside_next = inside_reg;
        if (push)
        begin
            inside_next = !s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
        end
    end

endmodule

/* src/rfb_queue.sv */
// short command queue between front end and frame sequencer
// depends on rfb_pkg
module rfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rfb_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output rfb_pkg::cmd_t      head_cmd,
    output rfb_pkg::q_status_t q_stat
);
    import rfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entries_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_cmd     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/rfb_back.sv */
// frame sequencer: walks header, payload and checksum bytes into the output register
// depends on rfb_pkg
module rfb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rfb_pkg::cfg_t      cfg,
    input  rfb_pkg::cmd_t      head_cmd,
    input  rfb_pkg::q_status_t q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] frame_byte
    output logic               m_tlast    // end_of_frame
);
    import rfb_pkg::*;

    logic       active_reg, active_next;
    logic [4:0] step_reg, step_next;
    logic [7:0] sum_reg, sum_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       advance;
    logic [4:0] eff_step;
    logic [2:0] addr_sel;
    logic [7:0] byte_sel;
    logic       cmd_done;

    assign advance  = !q_stat.empty && (!out_valid_reg || m_tready);
    // a fresh command starts at the header or, mid-frame, at its data byte
    assign eff_step = active_reg ? step_reg
                                 : (head_cmd.first_of_frame ? STEP_START : STEP_DATA);
    assign addr_sel = 3'(eff_step - STEP_ADDR);
    assign cmd_done = (eff_step == STEP_CHECK) ||
                      ((eff_step == STEP_DATA) && !head_cmd.last_of_frame);
    assign pop      = advance && cmd_done;

    always_comb
    begin
        case (eff_step)
            STEP_START:   byte_sel = START_BYTE;
            STEP_LEN_HI:  byte_sel = head_cmd.frame_len[15:8];
            STEP_LEN_LO:  byte_sel = head_cmd.frame_len[7:0];
            STEP_TYPE:    byte_sel = TYPE_TX_REQUEST;
            STEP_IDENT:   byte_sel = cfg.frame_ident;
            STEP_NET_HI:  byte_sel = cfg.dest_net_address[15:8];
            STEP_NET_LO:  byte_sel = cfg.dest_net_address[7:0];
            STEP_RADIUS:  byte_sel = cfg.broadcast_radius;
            STEP_OPTIONS: byte_sel = cfg.tx_option_bits;
            STEP_DATA:    byte_sel = head_cmd.data_byte;
            STEP_CHECK:   byte_sel = SUM_BASE - sum_reg;
            STEP_ADDR, STEP_ADDR + 5'd1, STEP_ADDR + 5'd2, STEP_ADDR + 5'd3,
            STEP_ADDR + 5'd4, STEP_ADDR + 5'd5, STEP_ADDR + 5'd6, STEP_ADDR + 5'd7:
                // most significant address byte first
                byte_sel = cfg.dest_address[{~addr_sel, 3'b000} +: 8];
            default:      byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            active_next    = !cmd_done;
            step_next      = eff_step + 1'b1;
            if (eff_step == STEP_START || eff_step == STEP_CHECK)
            begin
                sum_next = 8'h00;
            end
            else if (eff_step >= STEP_TYPE)
            begin
                sum_next = sum_reg + byte_sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= STEP_START;
            sum_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= (eff_step == STEP_CHECK);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule
